FILE: rtl/rip_pkg.sv
// Shared types, constants and helper functions for the radix integer parser.
`timescale 1ns / 1ps

package rip_pkg;

    localparam int ChW     = 21;
    localparam int RadixW  = 6;
    localparam int ValW    = 64;
    localparam int ProdW   = ValW + RadixW + 1;
    localparam int PaddrW  = 3;

    localparam logic [ChW-1:0] CH_ZERO  = 21'h30;
    localparam logic [ChW-1:0] CH_MINUS = 21'h2D;
    localparam logic [ChW-1:0] CH_PLUS  = 21'h2B;

    localparam logic [RadixW-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RadixW-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RadixW-1:0] RADIX_RESET = 6'd10;
    localparam logic [RadixW-1:0] DIGIT_NONE  = 6'd63;

    typedef enum logic [1:0] {
        MODE_I8  = 2'd0,
        MODE_I16 = 2'd1,
        MODE_I32 = 2'd2,
        MODE_I64 = 2'd3
    } mode_t;

    localparam mode_t MODE_RESET = MODE_I32;

    // register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    localparam logic signed [ValW-1:0] I64_MIN = {1'b1, {(ValW-1){1'b0}}};
    localparam logic signed [ValW-1:0] I64_NEG_MAX = {1'b1, {(ValW-2){1'b0}}, 1'b1};
    localparam logic signed [ValW-1:0] I32_MIN = -64'sd2147483648;
    localparam logic signed [ValW-1:0] I32_NEG_MAX = -64'sd2147483647;
    localparam logic signed [ValW-1:0] I16_MIN = -64'sd32768;
    localparam logic signed [ValW-1:0] I16_NEG_MAX = -64'sd32767;
    localparam logic signed [ValW-1:0] I8_MIN = -64'sd128;
    localparam logic signed [ValW-1:0] I8_NEG_MAX = -64'sd127;

    // record handed from the step stage to the finish stage
    typedef struct packed {
        logic [ValW-1:0] acc;
        logic            is_neg;
        logic            bad;
        mode_t           mode;
        logic            empty;
    } fin_t;

    // digit value, DIGIT_NONE for a non-digit
    function automatic logic [RadixW-1:0] digit_val(input logic [ChW-1:0] c);
        logic [RadixW-1:0] d;
        d = DIGIT_NONE;
        if (c inside {[21'h30:21'h39]})
            d = RadixW'(c - 21'h30);
        else if (c inside {[21'h61:21'h7A]})
            d = RadixW'(c - 21'h61) + 6'd10;
        else if (c inside {[21'h41:21'h5A]})
            d = RadixW'(c - 21'h41) + 6'd10;
        return d;
    endfunction

    // negated accumulation limit used during the digit loop
    function automatic logic signed [ValW-1:0] step_limit(input mode_t m, input logic neg);
        logic signed [ValW-1:0] l;
        if (m == MODE_I64)
            l = neg ? I64_MIN : I64_NEG_MAX;
        else
            l = neg ? I32_MIN : I32_NEG_MAX;
        return l;
    endfunction

    // lowest accumulator value that still lands in the selected range
    function automatic logic signed [ValW-1:0] final_bound(input mode_t m, input logic neg);
        logic signed [ValW-1:0] b;
        case (m)
            MODE_I8:  b = neg ? I8_MIN  : I8_NEG_MAX;
            MODE_I16: b = neg ? I16_MIN : I16_NEG_MAX;
            MODE_I32: b = neg ? I32_MIN : I32_NEG_MAX;
            MODE_I64: b = neg ? I64_MIN : I64_NEG_MAX;
            default:  b = I64_MIN;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/rip_step.sv
// Parse state and per-character sign/digit step with overflow check.
`timescale 1ns / 1ps

module rip_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic [rip_pkg::ChW-1:0]         ch,
    input  logic                            last,
    input  logic                            empty_req,
    input  logic [rip_pkg::RadixW-1:0]      radix,
    input  rip_pkg::mode_t                  width_mode,
    output rip_pkg::fin_t                   fin
);

    logic [rip_pkg::ValW-1:0] acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic                     first_reg, first_next;
    logic                     sign_only_reg, sign_only_next;
    logic                     failed_reg, failed_next;

    logic                              radix_ok;
    logic [rip_pkg::RadixW-1:0]        dval;
    logic signed [rip_pkg::ProdW-1:0]  acc_x;
    logic signed [rip_pkg::ProdW-1:0]  radix_x;
    logic signed [rip_pkg::ProdW-1:0]  prod;
    logic signed [rip_pkg::ProdW-1:0]  lim_d;
    logic signed [rip_pkg::ValW-1:0]   lim;
    logic                              fail_s;

    assign radix_ok = (radix >= rip_pkg::RADIX_MIN) && (radix <= rip_pkg::RADIX_MAX);
    assign dval     = rip_pkg::digit_val(ch);
    assign lim      = rip_pkg::step_limit(width_mode, neg_reg);
    assign acc_x    = $signed({{(rip_pkg::ProdW-rip_pkg::ValW){acc_reg[rip_pkg::ValW-1]}},
                               acc_reg});
    assign radix_x  = $signed({{(rip_pkg::ProdW-rip_pkg::RadixW){1'b0}}, radix});
    assign prod     = acc_x * radix_x;
    assign lim_d    = $signed({{(rip_pkg::ProdW-rip_pkg::ValW){lim[rip_pkg::ValW-1]}}, lim})
                    + $signed({{(rip_pkg::ProdW-rip_pkg::RadixW){1'b0}}, dval});

    always_comb
    begin
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        first_next     = first_reg;
        sign_only_next = sign_only_reg;
        failed_next    = failed_reg;
        fail_s         = 1'b0;

        if (!failed_reg)
        begin
            if (first_reg && (ch < rip_pkg::CH_ZERO))
            begin
                neg_next = neg_reg | (ch == rip_pkg::CH_MINUS);
                fail_s   = !((ch == rip_pkg::CH_MINUS) || (ch == rip_pkg::CH_PLUS));
                if (!fail_s)
                begin
                    sign_only_next = 1'b1;
                    fail_s         = last;
                end
                failed_next = fail_s | !radix_ok;
            end
            else
            begin
                sign_only_next = 1'b0;
                if (!radix_ok || (dval >= radix) || (prod < lim_d))
                    failed_next = 1'b1;
                else
                    acc_next = prod[rip_pkg::ValW-1:0]
                             - {{(rip_pkg::ValW-rip_pkg::RadixW){1'b0}}, dval};
            end
        end
        first_next = 1'b0;

        fin.acc    = acc_next;
        fin.is_neg = neg_next;
        fin.bad    = failed_next | sign_only_next;
        fin.mode   = width_mode;
        fin.empty  = empty_req;

        if (empty_req || last)
        begin
            acc_next       = '0;
            neg_next       = 1'b0;
            first_next     = 1'b1;
            sign_only_next = 1'b0;
            failed_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            first_reg     <= 1'b1;
            sign_only_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (adv)
        begin
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            first_reg     <= first_next;
            sign_only_reg <= sign_only_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

FILE: rtl/rip_finish.sv
// Final sign fix-up, range check and result register.
`timescale 1ns / 1ps

module rip_finish (
    input  logic                        clk,
    input  logic                        load,
    input  rip_pkg::fin_t               fin,
    output logic [rip_pkg::ValW-1:0]    value,
    output logic                        status
);

    logic [rip_pkg::ValW-1:0]        value_reg, value_next;
    logic                            status_reg, status_next;
    logic signed [rip_pkg::ValW-1:0] bound;
    logic                            in_range;
    logic                            bad;

    assign bound    = rip_pkg::final_bound(fin.mode, fin.is_neg);
    assign in_range = $signed(fin.acc) >= bound;
    assign bad      = fin.empty | fin.bad | !in_range;

    always_comb
    begin
        status_next = bad;
        if (bad)
            value_next = '0;
        else if (fin.is_neg)
            value_next = fin.acc;
        else
            value_next = '0 - fin.acc;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign value  = value_reg;
    assign status = status_reg;

endmodule

FILE: rtl/radix_integer_parser_unit.sv
// Top level of the radix integer parser: stream ports, register port, pipeline control.
// Stages: input register A, step record register B, result register driving m_tvalid.
// Throughput: one character per cycle while no string-ending character waits on the output;
// bounded by the digit step (one 64x6 multiply, subtract and compare on the parse state).
// Characters that end no string never wait on the output side.
// Reset (rst_n low, asynchronous): pipeline empty, radix 10, width int32, parse state cleared.
`timescale 1ns / 1ps

module radix_integer_parser_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // [20:0] ch
    input  logic                            s_tlast,
    input  logic                            s_tuser,   // [0] empty_req
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // [63:0] value
    output logic                            m_tuser,   // [0] status
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rip_pkg::PaddrW-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [rip_pkg::RadixW-1:0] radix_reg;
    rip_pkg::mode_t             mode_reg;
    logic                       cfg_wr;

    logic                       a_valid_reg, a_valid_next;
    logic [rip_pkg::ChW-1:0]    a_ch_reg;
    logic                       a_last_reg;
    logic                       a_empty_reg;
    logic                       b_valid_reg, b_valid_next;
    rip_pkg::fin_t              b_fin_reg;
    rip_pkg::fin_t              fin;
    logic                       m_valid_reg, m_valid_next;

    logic                       produces;
    logic                       out_free;
    logic                       b_free;
    logic                       a_adv;
    logic                       b_load;
    logic                       b_adv;
    logic                       s_acc;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rip_pkg::RADIX_RESET;
            mode_reg  <= rip_pkg::MODE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                rip_pkg::REG_RADIX: radix_reg <= pwdata[rip_pkg::RadixW-1:0];
                rip_pkg::REG_WIDTH: mode_reg  <= rip_pkg::mode_t'(pwdata[1:0]);
                default:            radix_reg <= radix_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            rip_pkg::REG_RADIX: prdata = {{(32-rip_pkg::RadixW){1'b0}}, radix_reg};
            rip_pkg::REG_WIDTH: prdata = {30'd0, mode_reg};
            default:            prdata = '0;
        endcase
    end

    // pipeline control
    assign produces = a_last_reg | a_empty_reg;
    assign out_free = !m_valid_reg | m_tready;
    assign b_adv    = b_valid_reg & out_free;
    assign b_free   = !b_valid_reg | out_free;
    assign a_adv    = a_valid_reg & (!produces | b_free);
    assign b_load   = a_adv & produces;
    assign s_tready = !a_valid_reg | a_adv;
    assign s_acc    = s_tvalid & s_tready;

    assign a_valid_next = s_acc | (a_valid_reg & !a_adv);
    assign b_valid_next = b_load | (b_valid_reg & !b_adv);
    assign m_valid_next = b_adv | (m_valid_reg & !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            a_ch_reg    <= s_tdata[rip_pkg::ChW-1:0];
            a_last_reg  <= s_tlast;
            a_empty_reg <= s_tuser;
        end
        if (b_load)
            b_fin_reg <= fin;
    end

    rip_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (a_adv),
        .ch         (a_ch_reg),
        .last       (a_last_reg),
        .empty_req  (a_empty_reg),
        .radix      (radix_reg),
        .width_mode (mode_reg),
        .fin        (fin)
    );

    rip_finish u_finish (
        .clk    (clk),
        .load   (b_adv),
        .fin    (b_fin_reg),
        .value  (m_tdata),
        .status (m_tuser)
    );

    assign m_tvalid = m_valid_reg;

endmodule

FILE: rtl/rip_checker.sv
// Port-level checker for the radix integer parser, bound to the top level.
`timescale 1ns / 1ps

module rip_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [63:0]                  m_tdata,
    input logic                         m_tuser,
    input logic                         pready
);

    // a failed parse always reports zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("error result with nonzero value");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // nothing comes out of an empty pipeline right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

    // an idle output side never keeps the input stalled
    a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !s_tready |=> s_tready || m_tvalid)
        else $error("input stalled with empty output");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind radix_integer_parser_unit rip_checker u_rip_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
